### rtl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg: shared types for the Laguerre polynomial evaluator
// Word formats of both channels, fixed result widths, sequencer states.
// ----------------------------------------------------------------------------
package lpe_pkg;

    localparam int ORDER_W = 5;
    localparam int POINT_W = 32;
    localparam int VAL_W   = 48;
    localparam int HALF_W  = VAL_W / 2;

    typedef struct packed {
        logic [ORDER_W-1:0]        order;
        logic signed [POINT_W-1:0] point;
    } src_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    overflow;
    } dst_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIFF,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } lpe_state_t;

endpackage

### rtl/lpe_div_cell.sv
// ----------------------------------------------------------------------------
// lpe_div_cell: one restoring division cell
// Develops one quotient bit and hands remainder and word to the next cell.
// ----------------------------------------------------------------------------
module lpe_div_cell #(
    parameter int DIV_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  logic [DIV_W-1:0]         rem_in,
    input  logic [lpe_pkg::VAL_W-1:0] word_in,
    input  logic [DIV_W-1:0]         dvs_in,
    output logic                     valid_out,
    output logic [DIV_W-1:0]         rem_out,
    output logic [lpe_pkg::VAL_W-1:0] word_out,
    output logic [DIV_W-1:0]         dvs_out
);
    import lpe_pkg::*;

    logic                 valid_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [VAL_W-1:0]     word_reg;
    logic [VAL_W-1:0]     word_next;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic                 ge;

    // shift in the next dividend bit, subtract when it fits
    assign trial     = {rem_in, word_in[VAL_W-1]};
    assign ge        = trial >= {1'b0, dvs_in};
    assign rem_next  = ge ? DIV_W'(trial - {1'b0, dvs_in}) : DIV_W'(trial);
    assign word_next = {word_in[VAL_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        word_reg <= word_next;
        dvs_reg  <= dvs_in;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign word_out  = word_reg;
    assign dvs_out   = dvs_reg;

endmodule

### rtl/lpe_div_chain.sv
// ----------------------------------------------------------------------------
// lpe_div_chain: row of division cells
// One cell per quotient bit; a word walks the row cell by cell.
// ----------------------------------------------------------------------------
module lpe_div_chain #(
    parameter int DIV_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIV_W-1:0]         rem_init,
    input  logic [lpe_pkg::VAL_W-1:0] dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic [lpe_pkg::VAL_W-1:0] quot
);
    import lpe_pkg::*;

    logic                 valid_tap [0:VAL_W];
    logic [DIV_W-1:0]     rem_tap   [0:VAL_W];
    logic [VAL_W-1:0]     word_tap  [0:VAL_W];
    logic [DIV_W-1:0]     dvs_tap   [0:VAL_W];

    assign valid_tap[0] = start;
    assign rem_tap[0]   = rem_init;
    assign word_tap[0]  = dividend;
    assign dvs_tap[0]   = divisor;

    for (genvar i = 0; i < VAL_W; i++)
    begin : g_cell
        lpe_div_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_tap[i]),
            .rem_in    (rem_tap[i]),
            .word_in   (word_tap[i]),
            .dvs_in    (dvs_tap[i]),
            .valid_out (valid_tap[i+1]),
            .rem_out   (rem_tap[i+1]),
            .word_out  (word_tap[i+1]),
            .dvs_out   (dvs_tap[i+1])
        );
    end

    assign done = valid_tap[VAL_W];
    assign quot = word_tap[VAL_W];

endmodule

### rtl/laguerre_polynomial_eval_core.sv
// ----------------------------------------------------------------------------
// laguerre_polynomial_eval_core: Laguerre polynomial L_n(x)
// Three-term recurrence on a shared multiplier, rounded division by k+1
// through a row of division cells, saturation to the 48-bit result.
// ----------------------------------------------------------------------------
//  channel | signals                         | word
//  --------+---------------------------------+-----------------------------
//  src     | src_valid, src_stall, src_word  | order (5b), point (Q16.16)
//  dst     | dst_valid, dst_stall, dst_word  | value (Q32.16), overflow
//
//  Orders 0 and 1 go straight to the result. Order n >= 2 runs n-1
//  recurrence steps, each set by the 48-cell division row it passes through.
//  One word at a time; the next word is taken while a result waits in dst.
//  Reset clears sequencer and valid bits only; dst_stall holds the result.
// ----------------------------------------------------------------------------
module laguerre_polynomial_eval_core #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  lpe_pkg::src_word_t   src_word,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output lpe_pkg::dst_word_t   dst_word
);
    import lpe_pkg::*;

    localparam int KW   = $clog2(MAX_ORDER + 1);
    localparam int A_W  = (((KW + 1 + FRAC_BITS) > POINT_W) ? (KW + 1 + FRAC_BITS)
                                                            : POINT_W) + 2;
    localparam int PH_W = A_W + HALF_W;
    localparam int P_W  = A_W + VAL_W;
    localparam int N_W  = P_W + 2;
    localparam int KP_W = KW + 1 + VAL_W;

    localparam logic signed [VAL_W-1:0] ONE_FX  = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    lpe_state_t               state_reg;
    lpe_state_t               state_next;

    logic [KW-1:0]            n_reg;
    logic [KW-1:0]            k_reg;
    logic signed [POINT_W-1:0] x_reg;
    logic signed [VAL_W-1:0]  prev_reg;
    logic signed [VAL_W-1:0]  cur_reg;
    logic                     ovf_reg;
    logic [PH_W-1:0]          plo_reg;
    logic [P_W-1:0]           prod_reg;
    logic signed [KP_W-1:0]   kp_reg;
    logic signed [N_W-1:0]    num_reg;
    logic                     neg_reg;
    logic                     pre_ovf_reg;
    logic                     dst_valid_reg;
    dst_word_t                dst_word_reg;

    logic                     accept_src;
    logic                     accept_dst;
    logic                     load_dst;
    logic [KW-1:0]            n_clamp;
    logic [KW-1:0]            dvs;
    logic signed [A_W-1:0]    a_val;
    logic [A_W-1:0]           amag;
    logic [VAL_W-1:0]         cmag;
    logic                     psign;
    logic [HALF_W-1:0]        c_half;
    logic [PH_W-1:0]          p_half;
    logic signed [KP_W-1:0]   kp_prod;
    logic signed [N_W-1:0]    prod_s;
    logic signed [N_W-1:0]    kp_s;
    logic signed [N_W-1:0]    num_next;
    logic                     num_neg;
    logic [N_W-1:0]           num_mag;
    logic [N_W-1:0]           half;
    logic [N_W-1:0]           dvd;
    logic                     pre_ovf;
    logic                     div_start;
    logic                     div_done;
    logic [VAL_W-1:0]         quot;
    logic [VAL_W-1:0]         lim;
    logic                     step_ovf;
    logic signed [VAL_W-1:0]  step_val;

    assign accept_src = src_valid && !src_stall;
    assign accept_dst = dst_valid_reg && !dst_stall;
    assign load_dst   = (state_reg == ST_DONE) && (!dst_valid_reg || !dst_stall);

    assign n_clamp = (32'(src_word.order) > MAX_ORDER) ? KW'(MAX_ORDER)
                                                       : KW'(src_word.order);
    assign dvs     = k_reg + KW'(1);

    // numerator: (2k+1-x)*cur - k*prev, all scaled by 2^(2F)
    assign a_val   = $signed(A_W'({k_reg, 1'b1}) << FRAC_BITS) - A_W'(x_reg);
    assign amag    = a_val[A_W-1] ? A_W'(-a_val) : A_W'(a_val);
    assign cmag    = cur_reg[VAL_W-1] ? VAL_W'(-cur_reg) : VAL_W'(cur_reg);
    assign psign   = a_val[A_W-1] ^ cur_reg[VAL_W-1];
    // one multiplier: low half of |cur| first, high half next cycle
    assign c_half  = (state_reg == ST_MUL_LO) ? cmag[HALF_W-1:0] : cmag[VAL_W-1:HALF_W];
    assign p_half  = amag * c_half;
    assign kp_prod = $signed({1'b0, k_reg}) * prev_reg;
    assign prod_s  = $signed({2'b00, prod_reg});
    assign kp_s    = N_W'(kp_reg) <<< FRAC_BITS;
    assign num_next = (psign ? -prod_s : prod_s) - kp_s;

    // round to nearest: (|num| + d/2) / d with d = (k+1)*2^F
    assign num_neg = num_reg[N_W-1];
    assign num_mag = num_neg ? N_W'(-num_reg) : N_W'(num_reg);
    assign half    = N_W'(dvs) << (FRAC_BITS - 1);
    assign dvd     = (num_mag + half) >> FRAC_BITS;
    assign pre_ovf = (dvd >> VAL_W) >= N_W'(dvs);
    assign div_start = (state_reg == ST_PREP);

    lpe_div_chain #(
        .DIV_W (KW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (dvd[VAL_W +: KW]),
        .dividend (dvd[VAL_W-1:0]),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (quot)
    );

    assign lim      = neg_reg ? VAL_W'(VAL_MIN) : VAL_W'(VAL_MAX);
    assign step_ovf = pre_ovf_reg || (quot > lim);
    assign step_val = step_ovf ? (neg_reg ? VAL_MIN : VAL_MAX)
                               : (neg_reg ? -$signed(quot) : $signed(quot));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_src)
                begin
                    state_next = (n_clamp <= KW'(1)) ? ST_DONE : ST_MUL_LO;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (dvs < n_reg) ? ST_MUL_LO : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_dst)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                n_reg    <= n_clamp;
                x_reg    <= src_word.point;
                k_reg    <= KW'(1);
                prev_reg <= ONE_FX;
                cur_reg  <= ONE_FX - VAL_W'(src_word.point);
                ovf_reg  <= 1'b0;
            end
            ST_MUL_LO:
            begin
                plo_reg <= p_half;
            end
            ST_MUL_HI:
            begin
                prod_reg <= P_W'(plo_reg) + (P_W'(p_half) << HALF_W);
                kp_reg   <= kp_prod;
            end
            ST_DIFF:
            begin
                num_reg <= num_next;
            end
            ST_PREP:
            begin
                neg_reg     <= num_neg;
                pre_ovf_reg <= pre_ovf;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= step_val;
                    ovf_reg  <= ovf_reg | step_ovf;
                    k_reg    <= dvs;
                end
            end
            ST_DONE:
            begin
                if (load_dst)
                begin
                    dst_word_reg.value    <= (n_reg == '0) ? ONE_FX : cur_reg;
                    dst_word_reg.overflow <= ovf_reg;
                end
            end
            default:
            begin
                ovf_reg <= ovf_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (load_dst)
        begin
            dst_valid_reg <= 1'b1;
        end
        else if (accept_dst)
        begin
            dst_valid_reg <= 1'b0;
        end
    end

    assign src_stall = (state_reg != ST_IDLE);
    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

    // division row only reports back while a step waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside of a step");

    // a step never runs past the requested order
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_LO) |-> (k_reg < n_reg))
        else $error("recurrence index past order");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && dst_valid_reg && dst_stall) |=> (state_reg == ST_DONE))
        else $error("result register overwritten while stalled");

endmodule

### dv/laguerre_polynomial_eval_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laguerre_polynomial_eval_core_checker: result predictor and comparator
// Watches both channels, computes L_n(x) for every accepted src word with the
// three-term recurrence in wide integer arithmetic, and compares each dst word
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module laguerre_polynomial_eval_core_checker #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_stall,
    input  lpe_pkg::src_word_t src_word,
    input  logic               dst_valid,
    input  logic               dst_stall,
    input  lpe_pkg::dst_word_t dst_word,
    output int                 fail_count,
    output int                 pending
);
    import lpe_pkg::*;

    localparam longint VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VALUE_MIN = -64'sh0000_8000_0000_0000;

    dst_word_t laguerre_q[$];

    function automatic dst_word_t laguerre_eval(src_word_t w);
        longint             x;
        longint             prev;
        longint             cur;
        longint             nxt;
        longint             coef;
        int                 n;
        logic signed [127:0] num;
        logic [127:0]       mag;
        logic [127:0]       div;
        logic [127:0]       quo;
        logic [127:0]       lim;
        logic               neg;
        logic               ovf;
        dst_word_t          res;
        n    = (w.order > MAX_ORDER) ? MAX_ORDER : int'(w.order);
        x    = longint'(w.point);
        prev = longint'(1) <<< FRAC_BITS;
        cur  = prev - x;
        ovf  = 1'b0;
        for (int k = 1; k < n; k++)
        begin
            coef = (longint'(2 * k + 1) <<< FRAC_BITS) - x;
            num  = 128'(signed'(coef)) * 128'(signed'(cur))
                 - 128'(signed'(longint'(k) <<< FRAC_BITS)) * 128'(signed'(prev));
            neg  = num[127];
            mag  = neg ? 128'(-num) : 128'(num);
            div  = 128'(k + 1) << FRAC_BITS;
            mag  = mag + (div >> 1);
            quo  = mag / div;
            lim  = neg ? (128'(1) << 47) : ((128'(1) << 47) - 1);
            if (quo > lim)
            begin
                ovf = 1'b1;
                nxt = neg ? VALUE_MIN : VALUE_MAX;
            end
            else
            begin
                nxt = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
            end
            prev = cur;
            cur  = nxt;
        end
        res.value    = (n == 0) ? prev[VAL_W-1:0] : cur[VAL_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    assign pending = laguerre_q.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                laguerre_q.push_back(laguerre_eval(src_word));
            if (dst_valid && !dst_stall)
            begin
                if (laguerre_q.size() == 0)
                begin
                    $error("dst word with no prediction waiting: value %0d overflow %0b",
                           dst_word.value, dst_word.overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    dst_word_t exp_w;
                    exp_w = laguerre_q.pop_front();
                    if (exp_w.value !== dst_word.value)
                    begin
                        $error("value: expected %0d, actual %0d", exp_w.value, dst_word.value);
                        fail_count <= fail_count + 1;
                    end
                    else if (exp_w.overflow !== dst_word.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               exp_w.overflow, dst_word.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/laguerre_polynomial_eval_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laguerre_polynomial_eval_core_tb: testbench top
// Directed corner words, then random orders and points under several idle and
// stall mixes plus one long dst hold-off; the checker does all comparison.
// ----------------------------------------------------------------------------
module laguerre_polynomial_eval_core_tb;
    import lpe_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 1000;

    typedef enum int {
        MODE_FREE,
        MODE_SRC_IDLE,
        MODE_DST_STALL,
        MODE_BOTH
    } idle_mode_t;

    logic       clk;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    src_word_t  src_word;
    logic       dst_valid;
    logic       dst_stall;
    dst_word_t  dst_word;
    int         fail_count;
    int         pending;
    idle_mode_t mode;
    logic       hold_req;
    int         quiet_cycles = 0;

    laguerre_polynomial_eval_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    laguerre_polynomial_eval_core_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_word   (src_word),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_word   (dst_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int idle_pct(idle_mode_t m, bit src_side);
        case (m)
            MODE_SRC_IDLE:  return src_side ? 57 : 0;
            MODE_DST_STALL: return src_side ? 0 : 57;
            MODE_BOTH:      return 19;
            default:        return 0;
        endcase
    endfunction

    // receiver: random stall per mode, or one long counted hold-off
    initial
    begin
        int held;
        bit hold_used;
        dst_stall = 1'b0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                dst_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                dst_stall <= 1'b0;
            end
            else
            begin
                dst_stall <= ($urandom_range(0, 99) < idle_pct(mode, 1'b0));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[laguerre_polynomial_eval_core] ERROR");
            $finish;
        end
    end

    task automatic send_word(logic [ORDER_W-1:0] ord, logic [POINT_W-1:0] pt);
        bit stalled;
        if ($urandom_range(0, 99) < idle_pct(mode, 1'b1))
        begin
            src_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct(mode, 1'b1));
        end
        src_valid      <= 1'b1;
        src_word.order <= ord;
        src_word.point <= pt;
        do
        begin
            @(negedge clk);
            stalled = src_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    task automatic send_random();
        int                 sel;
        logic [ORDER_W-1:0] ord;
        logic [POINT_W-1:0] pt;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            ord = ORDER_W'($urandom_range(17, 31));
        else if (sel < 14)
            ord = ORDER_W'(16);
        else
            ord = ORDER_W'($urandom_range(0, 12));
        sel = $urandom_range(0, 99);
        if (sel < 55)
            pt = POINT_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        else if (sel < 90)
            pt = $urandom;
        else
            pt = POINT_W'(int'($urandom_range(0, 64)) - 32) << 16;
        send_word(ord, pt);
    endtask

    initial
    begin
        logic [ORDER_W-1:0] dir_ord[6];
        logic [POINT_W-1:0] dir_pt[4];
        dir_ord      = '{ORDER_W'(0), ORDER_W'(1), ORDER_W'(2), ORDER_W'(16),
                         ORDER_W'(17), ORDER_W'(31)};
        dir_pt       = '{32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        rst_n        = 1'b0;
        src_valid    = 1'b0;
        src_word     = '0;
        hold_req     = 1'b0;
        mode         = MODE_FREE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_ord[i])
            foreach (dir_pt[j])
                send_word(dir_ord[i], dir_pt[j]);
        send_word(ORDER_W'(5), 32'hFFFF_FFFF);
        send_word(ORDER_W'(16), 32'h0000_8000);

        // long dst hold-off while src keeps offering, core backs up
        hold_req <= 1'b1;
        repeat (6) send_random();

        for (int m = 0; m < 4; m++)
        begin
            mode = idle_mode_t'(m);
            repeat (123) send_random();
        end
        src_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[laguerre_polynomial_eval_core] OK");
        else
            $display("[laguerre_polynomial_eval_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/lpe_pkg.sv
rtl/lpe_div_cell.sv
rtl/lpe_div_chain.sv
rtl/laguerre_polynomial_eval_core.sv
dv/laguerre_polynomial_eval_core_checker.sv
dv/laguerre_polynomial_eval_core_tb.sv
